// ----- rtl/obstacle_point_persistence_filter_defines.svh -----
// Assertion macros for the obstacle point persistence filter.
// Taken in by the top level only; needs clk and rst in scope.
`ifndef OBSTACLE_POINT_PERSISTENCE_FILTER_DEFINES_SVH
`define OBSTACLE_POINT_PERSISTENCE_FILTER_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define OPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define OPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/opf_pkg.sv -----
// Shared constants for the obstacle point persistence filter.
// No dependencies.
package opf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int AGE_W      = 8;
  localparam int HITS_W     = 8;
  localparam int EXPIRE_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS      = 2'd2;

  localparam logic [CFG_DATA_W-1:0] MATCH_DIST_SQ_RST = 32'd2601;
  localparam logic [EXPIRE_W-1:0]   EXPIRE_TICKS_RST  = 8'd50;
  localparam logic [HITS_W-1:0]     MIN_HITS_RST      = 8'd1;

  localparam logic [AGE_W-1:0]  AGE_MAX  = 8'hFF;
  localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;

endpackage

// ----- rtl/opf_in_if.sv -----
// Point/tick input channel: valid, ready and the item payload.
// Depends on nothing.
interface opf_in_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, mode, point_x, point_y, input ready);
  modport sink   (input valid, mode, point_x, point_y, output ready);
endinterface

// ----- rtl/opf_out_if.sv -----
// Confirmed point result channel: valid, ready and the result payload.
// Depends on nothing.
interface opf_out_if #(parameter int COORD_BITS = 16) ();
  logic                         valid;
  logic                         ready;
  logic                         point_valid;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         last;

  modport source (output valid, point_valid, out_x, out_y, last, input ready);
  modport sink   (input valid, point_valid, out_x, out_y, last, output ready);
endinterface

// ----- rtl/opf_cell.sv -----
// One table slot of the rotating entry ring.
// Takes its neighbour's entry on each advance, or the write data at its own position.
module opf_cell #(
  parameter int EW    = 48,
  parameter int IDX_W = 6,
  parameter int POS   = 0
) (
  input  logic             clk,
  input  logic             advance,
  input  logic [IDX_W-1:0] wr_pos,
  input  logic [EW-1:0]    wr_data,
  input  logic [EW-1:0]    nbr,
  output logic [EW-1:0]    data
);

  logic hit;

  assign hit = (wr_pos == IDX_W'(POS));

  always_ff @(posedge clk) begin
    if (advance) begin
      data <= hit ? wr_data : nbr;
    end
  end

endmodule

// ----- rtl/opf_dist.sv -----
// Squared coordinate differences between a table entry and the point, registered.
// Depends on nothing.
module opf_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [COORD_BITS-1:0]       ex,
  input  logic [COORD_BITS-1:0]       ey,
  input  logic [COORD_BITS-1:0]       px,
  input  logic [COORD_BITS-1:0]       py,
  output logic [2*COORD_BITS+1:0]     sx,
  output logic [2*COORD_BITS+1:0]     sy
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic        [COORD_BITS:0] ax;
  logic        [COORD_BITS:0] ay;

  assign dx = $signed({ex[COORD_BITS-1], ex}) - $signed({px[COORD_BITS-1], px});
  assign dy = $signed({ey[COORD_BITS-1], ey}) - $signed({py[COORD_BITS-1], py});
  assign ax = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
  assign ay = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= ax * ax;
      sy <= ay * ay;
    end
  end

endmodule

// ----- rtl/obstacle_point_persistence_filter.sv -----
// Obstacle point persistence filter. The table is a ring of TABLE_DEPTH cells that
// rotates one place per cycle during a pass, unless the output stalls a tick, past a
// single distance unit at slot 0. A point is accepted, then runs a prime step, a
// matching pass and a placement pass; a tick runs a pass that output stalls can hold,
// and its last result is given in the flush step after the pass. Expired entries are
// squeezed out during the tick pass by writing kept entries at a moving ring position.
module obstacle_point_persistence_filter #(
  parameter int TABLE_DEPTH = 64,
  parameter int COORD_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [opf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opf_pkg::CFG_DATA_W-1:0] cfg_data,
  opf_in_if.sink                         points,
  opf_out_if.source                      results
);

  `include "obstacle_point_persistence_filter_defines.svh"

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int AW     = opf_pkg::AGE_W;
  localparam int HW     = opf_pkg::HITS_W;
  localparam int EW     = 2*COORD_BITS + AW + HW;
  localparam int SQ_W   = 2*COORD_BITS + 2;
  localparam int SUM_W  = SQ_W + 1;
  localparam int CMP_W  = (SUM_W > opf_pkg::CFG_DATA_W) ? SUM_W : opf_pkg::CFG_DATA_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRIME, ST_SCAN, ST_PLACE, ST_TICK, ST_FLUSH
  } state_t;

  state_t state;

  logic [opf_pkg::CFG_DATA_W-1:0] thr;
  logic [opf_pkg::EXPIRE_W-1:0]   expire;
  logic [HW-1:0]                  min_hits;
  logic [IDX_W-1:0]               live;
  logic [IDX_W-1:0]               s;
  logic [IDX_W-1:0]               q;
  logic [IDX_W-1:0]               wr;
  logic [IDX_W-1:0]               best;
  logic [SUM_W-1:0]               best_d;
  logic                           found;
  logic [COORD_BITS-1:0]          px;
  logic [COORD_BITS-1:0]          py;
  logic                           pend_valid;
  logic [COORD_BITS-1:0]          pend_x;
  logic [COORD_BITS-1:0]          pend_y;
  logic                           out_valid;
  logic                           out_pv;
  logic [COORD_BITS-1:0]          out_x;
  logic [COORD_BITS-1:0]          out_y;
  logic                           out_last;

  logic [EW-1:0]         slot [TABLE_DEPTH];
  logic [EW-1:0]         wdata;
  logic                  advance;
  logic [COORD_BITS-1:0] hx, hy, nx, ny, dex, dey;
  logic [AW-1:0]         hage, age_inc;
  logic [HW-1:0]         hhits, hits_inc;
  logic [SQ_W-1:0]       sx, sy;
  logic [SUM_W-1:0]      sum;
  logic                  active, match, kept, emit, stall, out_free, last_step, place_hit;
  logic                  out_load;

  assign hx    = slot[0][EW-1 -: COORD_BITS];
  assign hy    = slot[0][AW+HW +: COORD_BITS];
  assign hage  = slot[0][HW +: AW];
  assign hhits = slot[0][0 +: HW];
  assign nx    = slot[1][EW-1 -: COORD_BITS];
  assign ny    = slot[1][AW+HW +: COORD_BITS];

  assign active    = (s < live);
  assign last_step = (s == LAST_IDX);
  assign age_inc   = (hage == opf_pkg::AGE_MAX) ? hage : hage + AW'(1);
  assign hits_inc  = (hhits == opf_pkg::HITS_MAX) ? hhits : hhits + HW'(1);
  assign sum       = SUM_W'(sx) + SUM_W'(sy);
  assign match     = active && (CMP_W'(sum) < CMP_W'(thr));
  assign kept      = active && (age_inc <= expire);
  assign emit      = kept && (hhits >= min_hits);
  assign out_free  = !out_valid || results.ready;
  assign stall     = emit && pend_valid && !out_free;
  assign place_hit = found ? (s == best) : ((s == live) && (live != LAST_IDX));
  assign out_load  = ((state == ST_TICK) && !stall && emit && pend_valid) ||
                     ((state == ST_FLUSH) && out_free);

  always_comb begin
    case (state)
      ST_SCAN:  wdata = {hx, hy, hage, match ? hits_inc : hhits};
      ST_PLACE: wdata = place_hit ? {px, py, AW'(0), HW'(found)} : slot[0];
      ST_TICK:  wdata = {hx, hy, age_inc, hhits};
      default:  wdata = slot[0];
    endcase
  end

  always_comb begin
    case (state)
      ST_SCAN, ST_PLACE: advance = 1'b1;
      ST_TICK:           advance = !stall;
      default:           advance = 1'b0;
    endcase
  end

  assign dex = (state == ST_PRIME) ? hx : nx;
  assign dey = (state == ST_PRIME) ? hy : ny;

  opf_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk (clk),
    .en  ((state == ST_PRIME) || (state == ST_SCAN)),
    .ex  (dex),
    .ey  (dey),
    .px  (px),
    .py  (py),
    .sx  (sx),
    .sy  (sy)
  );

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    opf_cell #(.EW(EW), .IDX_W(IDX_W), .POS(j)) u_cell (
      .clk     (clk),
      .advance (advance),
      .wr_pos  (q),
      .wr_data (wdata),
      .nbr     (slot[(j + 1) % TABLE_DEPTH]),
      .data    (slot[j])
    );
  end

  assign points.ready        = (state == ST_IDLE);
  assign results.valid       = out_valid;
  assign results.point_valid = out_pv;
  assign results.out_x       = out_x;
  assign results.out_y       = out_y;
  assign results.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      live       <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      thr        <= opf_pkg::MATCH_DIST_SQ_RST;
      expire     <= opf_pkg::EXPIRE_TICKS_RST;
      min_hits   <= opf_pkg::MIN_HITS_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          opf_pkg::CFG_MATCH_DIST_SQ: thr      <= cfg_data;
          opf_pkg::CFG_EXPIRE_TICKS:  expire   <= cfg_data[opf_pkg::EXPIRE_W-1:0];
          opf_pkg::CFG_MIN_HITS:      min_hits <= cfg_data[HW-1:0];
          default: ;
        endcase
      end
      if (results.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (points.valid) begin
            px    <= points.point_x;
            py    <= points.point_y;
            s     <= '0;
            q     <= LAST_IDX;
            wr    <= '0;
            found <= 1'b0;
            state <= points.mode ? ST_TICK : ST_PRIME;
          end
        end
        ST_PRIME: state <= ST_SCAN;
        ST_SCAN: begin
          if (match && (!found || sum < best_d)) begin
            found  <= 1'b1;
            best   <= s;
            best_d <= sum;
          end
          s <= last_step ? '0 : s + IDX_W'(1);
          if (last_step) begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          s <= s + IDX_W'(1);
          if (last_step) begin
            if (!found && live != LAST_IDX) begin
              live <= live + IDX_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (!stall) begin
            s <= s + IDX_W'(1);
            if (kept) begin
              wr <= wr + IDX_W'(1);
            end else begin
              q <= (q == '0) ? LAST_IDX : q - IDX_W'(1);
            end
            if (emit) begin
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_pv    <= 1'b1;
                out_x     <= pend_x;
                out_y     <= pend_y;
                out_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_x     <= hx;
              pend_y     <= hy;
            end
            if (last_step) begin
              live  <= kept ? wr + IDX_W'(1) : wr;
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_pv     <= pend_valid;
            out_x      <= pend_valid ? pend_x : '0;
            out_y      <= pend_valid ? pend_y : '0;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `OPF_ASSERT_NEXT(a_accept_busy, points.valid && points.ready, state != ST_IDLE, "item accepted but block stayed idle")
  `OPF_ASSERT_NOW(a_pend_in_tick, pend_valid, state == ST_TICK || state == ST_FLUSH, "pending result outside a tick")
  `OPF_ASSERT_NOW(a_live_bound, 1'b1, live <= LAST_IDX, "live count beyond table capacity")
  `OPF_ASSERT_NEXT(a_flush_last, state == ST_FLUSH && out_free, out_valid && out_last, "tick ended without a last beat")

endmodule

// ----- test/obstacle_point_persistence_filter_tb.sv -----
// Testbench for obstacle_point_persistence_filter: drives point and tick beats,
// predicts every result from an internal copy of the obstacle table and checks it.
// Depends on opf_pkg, opf_in_if, opf_out_if and the filter itself from the RTL.
`timescale 1ns / 100ps

typedef struct {
  bit                 point_valid;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  bit                 last;
} confirmed_point_t;

class persistence_scoreboard;
  localparam int DEPTH = 64;
  logic signed [15:0] cell_x[DEPTH];
  logic signed [15:0] cell_y[DEPTH];
  logic [7:0]         cell_age[DEPTH];
  logic [7:0]         cell_hits[DEPTH];
  int unsigned        live;
  logic [31:0]        dist_limit;
  logic [7:0]         expiry;
  logic [7:0]         hits_needed;
  confirmed_point_t   confirmed_q[$];
  int                 failures;
  int                 points_seen;
  int                 ticks_seen;
  int                 results_seen;

  function new();
    live        = 0;
    dist_limit  = opf_pkg::MATCH_DIST_SQ_RST;
    expiry      = opf_pkg::EXPIRE_TICKS_RST;
    hits_needed = opf_pkg::MIN_HITS_RST;
  endfunction

  function void write_reg(logic [opf_pkg::CFG_IDX_W-1:0] idx,
                          logic [opf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      opf_pkg::CFG_MATCH_DIST_SQ: dist_limit = data;
      opf_pkg::CFG_EXPIRE_TICKS:  expiry = data[7:0];
      opf_pkg::CFG_MIN_HITS:      hits_needed = data[7:0];
      default: ;
    endcase
  endfunction

  function void absorb_point(logic signed [15:0] px, logic signed [15:0] py);
    longint dx, dy;
    logic [63:0] d, best_d;
    int best;
    bit found;
    found = 0;
    best = 0;
    best_d = 0;
    for (int i = 0; i < live; i++) begin
      dx = longint'(cell_x[i]) - longint'(px);
      dy = longint'(cell_y[i]) - longint'(py);
      d = dx * dx + dy * dy;
      if (d < {32'd0, dist_limit}) begin
        if (cell_hits[i] != opf_pkg::HITS_MAX) cell_hits[i]++;
        if (!found || d < best_d) begin
          found = 1;
          best = i;
          best_d = d;
        end
      end
    end
    if (found) begin
      cell_x[best] = px;
      cell_y[best] = py;
      cell_age[best] = 0;
      cell_hits[best] = 1;
    end else if (live + 1 < DEPTH) begin
      cell_x[live] = px;
      cell_y[live] = py;
      cell_age[live] = 0;
      cell_hits[live] = 0;
      live++;
    end
  endfunction

  function void age_and_emit();
    int wr, n;
    logic [7:0] age;
    confirmed_point_t r;
    wr = 0;
    n = 0;
    for (int rd = 0; rd < live; rd++) begin
      age = cell_age[rd];
      if (age != opf_pkg::AGE_MAX) age++;
      if (age > expiry) continue;
      cell_x[wr] = cell_x[rd];
      cell_y[wr] = cell_y[rd];
      cell_hits[wr] = cell_hits[rd];
      cell_age[wr] = age;
      if (cell_hits[wr] >= hits_needed && n < DEPTH - 1) begin
        r = '{1'b1, cell_x[wr], cell_y[wr], 1'b0};
        confirmed_q = {confirmed_q, r};
        n++;
      end
      wr++;
    end
    live = wr;
    if (n == 0) begin
      r = '{1'b0, 16'sd0, 16'sd0, 1'b1};
      confirmed_q = {confirmed_q, r};
    end else begin
      confirmed_q[confirmed_q.size() - 1].last = 1'b1;
    end
  endfunction

  function void note_item(bit mode, logic signed [15:0] px, logic signed [15:0] py);
    if (mode) begin
      ticks_seen++;
      age_and_emit();
    end else begin
      points_seen++;
      absorb_point(px, py);
    end
  endfunction

  function void check_result(bit pv, logic signed [15:0] ox, logic signed [15:0] oy, bit lst);
    confirmed_point_t e;
    results_seen++;
    if (confirmed_q.size() == 0) begin
      $error("result beat with nothing expected: point_valid %0d x %0d y %0d last %0d",
             pv, ox, oy, lst);
      failures++;
      return;
    end
    e = confirmed_q.pop_front();
    if (pv !== e.point_valid) begin
      $error("point_valid expected %0d got %0d", e.point_valid, pv);
      failures++;
    end
    if (ox !== e.out_x) begin
      $error("out_x expected %0d got %0d", e.out_x, ox);
      failures++;
    end
    if (oy !== e.out_y) begin
      $error("out_y expected %0d got %0d", e.out_y, oy);
      failures++;
    end
    if (lst !== e.last) begin
      $error("last expected %0d got %0d", e.last, lst);
      failures++;
    end
  endfunction
endclass

module obstacle_point_persistence_filter_tb;

  localparam int SETTLE_CYCLES = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_we = 0;
  logic [opf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [opf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  opf_in_if  #(.COORD_BITS(16)) points ();
  opf_out_if #(.COORD_BITS(16)) results ();

  persistence_scoreboard table_sb = new();
  bit idle_on = 1;
  bit hold_request = 0;
  int quiet_cycles = 0;

  obstacle_point_persistence_filter #(.TABLE_DEPTH(64), .COORD_BITS(16)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .points(points.sink), .results(results.source)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    points.valid = 0;
    points.mode = 0;
    points.point_x = '0;
    points.point_y = '0;
    results.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready)
        table_sb.check_result(results.point_valid, results.out_x, results.out_y, results.last);
      if (points.valid && points.ready)
        table_sb.note_item(points.mode, points.point_x, points.point_y);
      if ((points.valid && points.ready) || (results.valid && results.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        results.ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
        results.ready <= 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        results.ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        results.ready <= 1;
      end else begin
        results.ready <= 1;
      end
    end
  end

  task automatic send_item(bit m, logic signed [15:0] x, logic signed [15:0] y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      points.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    points.valid <= 1;
    points.mode <= m;
    points.point_x <= x;
    points.point_y <= y;
    do @(posedge clk); while (!points.ready);
  endtask

  task automatic settle();
    points.valid <= 0;
    @(posedge clk);
    while (table_sb.confirmed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [opf_pkg::CFG_IDX_W-1:0] idx,
                         logic [opf_pkg::CFG_DATA_W-1:0] data);
    settle();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    table_sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_burst(int count, int spread);
    logic signed [15:0] cx[4], cy[4];
    int k, r;
    foreach (cx[i]) begin
      cx[i] = 16'($urandom);
      cy[i] = 16'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      k = $urandom_range(0, 3);
      if (r < 2)
        send_item(1'b1, 16'($urandom), 16'($urandom));
      else if (r < 3)
        send_item(1'b0, 16'($urandom), 16'($urandom));
      else
        send_item(1'b0, 16'(cx[k] + $signed($urandom_range(0, 2 * spread)) - spread),
                  16'(cy[k] + $signed($urandom_range(0, 2 * spread)) - spread));
    end
    send_item(1'b1, 16'sd0, 16'sd0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes and corners at reset settings
    send_item(1'b0, -16'sd32768, -16'sd32768);
    send_item(1'b0, 16'sd32767, 16'sd32767);
    send_item(1'b0, -16'sd32768, 16'sd32767);
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b0, -16'sd1, -16'sd1);
    send_item(1'b0, 16'sd10, 16'sd10);
    send_item(1'b1, 16'sd32767, -16'sd32768);
    send_item(1'b0, 16'sd32767, -16'sd32768);
    send_item(1'b1, 16'sd0, 16'sd0);

    // widest threshold: corners still too far apart to match
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'hFFFF_FFFF);
    send_item(1'b0, 16'sd32767, 16'sd32767);
    send_item(1'b0, -16'sd32768, -16'sd32768);
    send_item(1'b1, 16'sd0, 16'sd0);

    // nothing confirmed
    set_reg(opf_pkg::CFG_MIN_HITS, 32'd255);
    send_item(1'b1, 16'sd0, 16'sd0);

    // everything expires on the first tick
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd0);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd0, 16'sd0);

    // equal distances: lowest index wins
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'd0);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd255);
    set_reg(opf_pkg::CFG_MIN_HITS, 32'd0);
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd20, 16'sd0);
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'd101);
    send_item(1'b0, 16'sd10, 16'sd0);
    send_item(1'b1, 16'sd0, 16'sd0);

    // fill the table past capacity, then stall the receiver on a full tick
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'd0);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd254);
    set_reg(opf_pkg::CFG_MIN_HITS, 32'd0);
    for (int i = 0; i < 65; i++) send_item(1'b0, 16'($urandom), 16'($urandom));
    hold_request = 1;
    for (int i = 0; i < 3; i++) send_item(1'b1, 16'sd0, 16'sd0);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd0);
    send_item(1'b1, 16'sd0, 16'sd0);

    // random traffic over several settings
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, opf_pkg::MATCH_DIST_SQ_RST);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'(opf_pkg::EXPIRE_TICKS_RST));
    set_reg(opf_pkg::CFG_MIN_HITS, 32'(opf_pkg::MIN_HITS_RST));
    random_burst(5, 60);
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'd4000);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd5);
    set_reg(opf_pkg::CFG_MIN_HITS, 32'd2);
    random_burst(5, 80);
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'd400);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd254);
    set_reg(opf_pkg::CFG_MIN_HITS, 32'd0);
    random_burst(5, 25);
    idle_on = 0;
    set_reg(opf_pkg::CFG_MATCH_DIST_SQ, 32'd90000);
    set_reg(opf_pkg::CFG_EXPIRE_TICKS, 32'd3);
    set_reg(opf_pkg::CFG_MIN_HITS, 32'd1);
    random_burst(5, 400);

    settle();
    $display("covered %0d points and %0d ticks, %0d result beats checked",
             table_sb.points_seen, table_sb.ticks_seen, table_sb.results_seen);
    $display("included table overflow, expiry, tie-break and a long output stall");
    if (table_sb.failures == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- obstacle_point_persistence_filter.f -----
+incdir+rtl
rtl/opf_pkg.sv
rtl/opf_in_if.sv
rtl/opf_out_if.sv
rtl/opf_cell.sv
rtl/opf_dist.sv
rtl/obstacle_point_persistence_filter.sv
test/obstacle_point_persistence_filter_tb.sv
